FILE: hdl/pmd_pkg.sv
// Shared types and constants for the peak meter with decay.
package pmd_pkg;

    // Sample and peak widths
    localparam int SAMPLE_BITS = 16;
    localparam int FS_BITS     = SAMPLE_BITS - 1;
    localparam int PEAK_W      = FS_BITS;
    localparam logic [PEAK_W-1:0] MAG_MAX = {PEAK_W{1'b1}};

    // Log conversion
    localparam int EXP_W         = $clog2(FS_BITS);
    localparam int MANT_W        = 16;
    localparam int LOG_FRAC_BITS = 12;
    localparam int NORM_W        = FS_BITS + MANT_W;
    localparam int SHIFT_W       = $clog2(NORM_W);
    localparam int DIFF_W        = $clog2(FS_BITS * (1 << LOG_FRAC_BITS) + 1);
    localparam int COEF_W        = 15;
    localparam int PROD_W        = DIFF_W + COEF_W;
    localparam int MAGDB_W       = PROD_W - 16;
    localparam int DB_PER_LOG2   = 24660;
    localparam logic [PEAK_W-1:0] FLOOR_LEVEL = PEAK_W'((1 << FS_BITS) / 10000);

    // dBFS range, Q8.8
    localparam int DB_W         = 16;
    localparam int DB_FLOOR_MAG = 20480;
    localparam logic signed [DB_W-1:0] DB_MIN = -16'sd20480;
    localparam logic signed [DB_W-1:0] DB_MAX = 16'sd1536;

    // Output field width
    localparam int LEVEL_W = 16;

    // Decay coefficient, Q0.16
    localparam int DECAY_W = 16;
    localparam logic [DECAY_W-1:0] DECAY_LO    = 16'd32768;
    localparam logic [DECAY_W-1:0] DECAY_HI    = 16'd65470;
    localparam logic [DECAY_W-1:0] DECAY_RESET = 16'd62259;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OUTPUT_MODE  = CFG_IDX_W'(0),
        CFG_DECAY_FACTOR = CFG_IDX_W'(1)
    } pmd_cfg_idx_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          end_of_block;
    } pmd_in_t;

    typedef struct packed {
        logic signed [LEVEL_W-1:0] level;
        logic signed [DB_W-1:0]    peak_db;
    } pmd_out_t;

    // One slot of the log pipeline
    typedef struct packed {
        logic [PEAK_W-1:0]        peak;
        logic                     floor_hit;
        logic [EXP_W-1:0]         expo;
        logic [MANT_W-1:0]        mant;
        logic [LOG_FRAC_BITS-1:0] frac;
    } pmd_lane_t;

endpackage

FILE: hdl/pmd_front.sv
// Input register, block maximum and held peak update.
module pmd_front import pmd_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  pmd_in_t             s_data,
    input  logic [DECAY_W-1:0]  decay_factor,
    output logic                peak_valid,
    input  logic                peak_ready,
    output logic [PEAK_W-1:0]   peak_value
);

    logic                     in_valid_reg;
    logic [PEAK_W-1:0]        mag_reg;
    logic                     eob_reg;
    logic [PEAK_W-1:0]        block_max_reg;
    logic [PEAK_W-1:0]        held_peak_reg;

    logic [SAMPLE_BITS-1:0]   raw;
    logic [SAMPLE_BITS-1:0]   raw_abs;
    logic [PEAK_W-1:0]        mag_next;
    logic [PEAK_W-1:0]        blk_max;
    logic [PEAK_W-1:0]        peak_diff;
    logic [PEAK_W+DECAY_W-1:0] decay_prod;
    logic [PEAK_W-1:0]        held_peak_next;
    logic                     item_take;

    // Magnitude, saturated at full scale minus one
    always_comb begin
        raw     = s_data.sample;
        raw_abs = raw[SAMPLE_BITS-1] ? SAMPLE_BITS'(~raw + 1'b1) : raw;
        mag_next = raw_abs[SAMPLE_BITS-1] ? MAG_MAX : raw_abs[PEAK_W-1:0];
    end

    // Release: peak*d + max*(1-d) == max + (peak-max)*d
    always_comb begin
        blk_max    = (mag_reg > block_max_reg) ? mag_reg : block_max_reg;
        peak_diff  = held_peak_reg - blk_max;
        decay_prod = (PEAK_W+DECAY_W)'(peak_diff) * (PEAK_W+DECAY_W)'(decay_factor);
        if (blk_max >= held_peak_reg) begin
            held_peak_next = blk_max;
        end else begin
            held_peak_next = blk_max + decay_prod[PEAK_W+DECAY_W-1:DECAY_W];
        end
    end

    assign item_take  = in_valid_reg && (!eob_reg || peak_ready);
    assign s_ready    = !in_valid_reg || !eob_reg || peak_ready;
    assign peak_valid = in_valid_reg && eob_reg;
    assign peak_value = held_peak_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            block_max_reg <= '0;
            held_peak_reg <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (item_take) begin
                if (eob_reg) begin
                    held_peak_reg <= held_peak_next;
                    block_max_reg <= '0;
                end else begin
                    block_max_reg <= blk_max;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            mag_reg <= mag_next;
            eob_reg <= s_data.end_of_block;
        end
    end

endmodule

FILE: hdl/pmd_log_pipe.sv
// Pipelined peak-to-dBFS conversion and result register.
module pmd_log_pipe import pmd_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               output_mode,
    input  logic               peak_valid,
    output logic               peak_ready,
    input  logic [PEAK_W-1:0]  peak_value,
    output logic               m_valid,
    input  logic               m_ready,
    output pmd_out_t           m_data
);

    // Stage 0 holds the peak, stage 1 normalizes, the rest square once each
    localparam int LAST = LOG_FRAC_BITS + 1;
    localparam int NSTG = LAST + 1;

    pmd_lane_t              lane_reg  [NSTG];
    pmd_lane_t              lane_next [NSTG];
    logic [NSTG-1:0]        valid_reg;
    logic [NSTG-1:0]        stage_ready;

    logic                   scale_valid_reg;
    logic [PEAK_W-1:0]      scale_peak_reg;
    logic                   scale_floor_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [PROD_W-1:0]      prod_next;
    logic [DIFF_W-1:0]      log_diff;
    logic                   scale_ready;

    logic                   m_valid_reg;
    pmd_out_t               out_reg;
    pmd_out_t               out_next;
    logic                   out_ready;
    logic [MAGDB_W-1:0]     mag_db;
    logic signed [DB_W-1:0] db_val;

    function automatic pmd_lane_t norm_step(input pmd_lane_t a);
        pmd_lane_t         r;
        logic [EXP_W-1:0]  e;
        logic [NORM_W-1:0] w;
        r = a;
        e = '0;
        for (int i = 0; i < PEAK_W; i++) begin
            if (a.peak[i]) begin
                e = EXP_W'(i);
            end
        end
        // Put the leading one at the top; the top bits are the Q1.15 mantissa
        w = NORM_W'(a.peak) << (SHIFT_W'(NORM_W - 1) - SHIFT_W'(e));
        r.floor_hit = (a.peak <= FLOOR_LEVEL);
        r.expo      = e;
        r.mant      = w[NORM_W-1 -: MANT_W];
        r.frac      = '0;
        return r;
    endfunction

    function automatic pmd_lane_t square_step(input pmd_lane_t a);
        pmd_lane_t           r;
        logic [2*MANT_W-1:0] sq;
        logic [MANT_W:0]     t;
        r  = a;
        sq = (2*MANT_W)'(a.mant) * (2*MANT_W)'(a.mant);
        t  = sq[2*MANT_W-1:MANT_W-1];
        // A square past 2.0 yields a one bit of log2 and renormalizes
        if (t[MANT_W]) begin
            r.mant = t[MANT_W:1];
            r.frac = {a.frac[LOG_FRAC_BITS-2:0], 1'b1};
        end else begin
            r.mant = t[MANT_W-1:0];
            r.frac = {a.frac[LOG_FRAC_BITS-2:0], 1'b0};
        end
        return r;
    endfunction

    assign out_ready   = !m_valid_reg || m_ready;
    assign scale_ready = !scale_valid_reg || out_ready;

    always_comb begin
        stage_ready[LAST] = !valid_reg[LAST] || scale_ready;
        for (int k = LAST - 1; k >= 0; k--) begin
            stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
        end
    end

    assign peak_ready = stage_ready[0];

    always_comb begin
        lane_next[0]      = '0;
        lane_next[0].peak = peak_value;
        lane_next[1]      = norm_step(lane_reg[0]);
        for (int k = 2; k < NSTG; k++) begin
            lane_next[k] = square_step(lane_reg[k-1]);
        end
    end

    // Distance below full scale in log2, then scale to dB
    always_comb begin
        log_diff  = DIFF_W'(FS_BITS << LOG_FRAC_BITS)
                  - DIFF_W'({lane_reg[LAST].expo, lane_reg[LAST].frac});
        prod_next = PROD_W'(log_diff) * PROD_W'(DB_PER_LOG2);
    end

    always_comb begin
        mag_db = prod_reg[PROD_W-1:16];
        if (scale_floor_reg || (32'(mag_db) > 32'(DB_FLOOR_MAG))) begin
            db_val = DB_MIN;
        end else begin
            db_val = -$signed(DB_W'(mag_db));
        end
        out_next.peak_db = db_val;
        out_next.level   = output_mode ? db_val : $signed(LEVEL_W'(scale_peak_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg       <= '0;
            scale_valid_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (stage_ready[0]) begin
                valid_reg[0] <= peak_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (stage_ready[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
            if (scale_ready) begin
                scale_valid_reg <= valid_reg[LAST];
            end
            if (out_ready) begin
                m_valid_reg <= scale_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < NSTG; k++) begin
            if (stage_ready[k]) begin
                lane_reg[k] <= lane_next[k];
            end
        end
        if (scale_ready) begin
            scale_peak_reg  <= lane_reg[LAST].peak;
            scale_floor_reg <= lane_reg[LAST].floor_hit;
            prod_reg        <= prod_next;
        end
        if (out_ready) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

FILE: hdl/peak_meter_with_decay.sv
// Peak meter with instant attack, exponential release and dBFS readout.
//
//  channel | ports                         | payload
//  --------+-------------------------------+-----------------------------
//  input   | s_valid, s_ready, s_data      | sample, end_of_block
//  result  | m_valid, m_ready, m_data      | level, peak_db (one per block)
//  config  | cfg_we, cfg_index, cfg_wdata  | output_mode, decay_factor
//
// One sample transaction per cycle while s_ready is high. A result passes
// through the log2 pipeline, whose twelve squaring stages do one 16x16
// multiply each. Reset clears the valid bits, block maximum and held peak and
// presets the configuration registers. Every stage holds only while the stage
// after it is full and stalled, so bubbles close up and input keeps flowing.
module peak_meter_with_decay import pmd_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  pmd_in_t               s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output pmd_out_t              m_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic                output_mode_reg;
    logic [DECAY_W-1:0]  decay_factor_reg;
    logic [DECAY_W-1:0]  decay_factor_next;
    logic                peak_valid;
    logic                peak_ready;
    logic [PEAK_W-1:0]   peak_value;

    // Clamp decay writes into 0.5..0.999
    always_comb begin
        decay_factor_next = DECAY_W'(cfg_wdata);
        if (decay_factor_next < DECAY_LO) begin
            decay_factor_next = DECAY_LO;
        end else if (decay_factor_next > DECAY_HI) begin
            decay_factor_next = DECAY_HI;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            output_mode_reg  <= 1'b0;
            decay_factor_reg <= DECAY_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_OUTPUT_MODE:  output_mode_reg  <= cfg_wdata[0];
                CFG_DECAY_FACTOR: decay_factor_reg <= decay_factor_next;
                default: ;  // drop writes to unmapped indexes
            endcase
        end
    end

    pmd_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .decay_factor (decay_factor_reg),
        .peak_valid   (peak_valid),
        .peak_ready   (peak_ready),
        .peak_value   (peak_value)
    );

    pmd_log_pipe u_log_pipe (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .output_mode (output_mode_reg),
        .peak_valid  (peak_valid),
        .peak_ready  (peak_ready),
        .peak_value  (peak_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

FILE: hdl/pmd_checker.sv
// Port-level assertions for the peak meter, bound to the top level.
module pmd_port_checker import pmd_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  pmd_in_t               s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  pmd_out_t              m_data
);

    localparam int PEND_W = 6;

    logic [PEND_W-1:0] pending_reg;
    logic              blk_in;
    logic              res_out;

    assign blk_in  = s_valid && s_ready && s_data.end_of_block;
    assign res_out = m_valid && m_ready;

    // Count closed blocks whose result has not left yet
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_reg + PEND_W'(blk_in) - PEND_W'(res_out);
        end
    end

    a_reset_clears_result: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_result_needs_block: assert property (@(posedge aclk) disable iff (!aresetn)
        res_out |-> (pending_reg != '0))
        else $error("result without a closed block");

    a_db_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_data.peak_db >= DB_MIN) && (m_data.peak_db <= DB_MAX)))
        else $error("peak_db outside -80..+6 dB");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("stalled result changed");

endmodule

bind peak_meter_with_decay pmd_port_checker u_pmd_checker (.*);

FILE: sim/pmd_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the peak meter: tracks its registers, predicts each block reading, compares.
module pmd_checker import pmd_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  pmd_in_t               s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  pmd_out_t              m_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                    mismatch_count,
    output int                    readings_due
);

    logic                     mode_sel;
    logic [DECAY_W-1:0]       decay;
    logic [PEAK_W-1:0]        block_max;
    logic [PEAK_W-1:0]        held_peak;
    logic signed [DB_W-1:0]   held_db;
    pmd_out_t                 due_readings [$];

    // Q0.15 peak to dBFS in Q8.8 via a squaring log2
    function automatic logic signed [DB_W-1:0] dbfs_of(input logic [PEAK_W-1:0] p);
        int          msb;
        int          i;
        logic [63:0] m;
        logic [63:0] lg;
        logic [63:0] d;
        logic [63:0] mag;
        int          dbv;
        if (p <= FLOOR_LEVEL)
            return DB_MIN;
        msb = 0;
        for (i = 0; i < PEAK_W; i++)
            if (p[i])
                msb = i;
        m  = 64'(p) << (15 - msb);
        lg = 64'(msb) << LOG_FRAC_BITS;
        for (i = LOG_FRAC_BITS - 1; i >= 0; i--) begin
            m = (m * m) >> 15;
            if (m >= 64'd65536) begin
                lg[i] = 1'b1;
                m = m >> 1;
            end
        end
        d   = (64'(FS_BITS) << LOG_FRAC_BITS) - lg;
        mag = (d * 64'(DB_PER_LOG2)) >> 16;
        dbv = -int'(mag);
        if (dbv < int'(DB_MIN))
            dbv = int'(DB_MIN);
        if (dbv > int'(DB_MAX))
            dbv = int'(DB_MAX);
        return DB_W'(dbv);
    endfunction

    task automatic latch_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_OUTPUT_MODE: begin
                mode_sel = data[0];
            end
            CFG_DECAY_FACTOR: begin
                if (data < DECAY_LO)
                    decay = DECAY_LO;
                else if (data > DECAY_HI)
                    decay = DECAY_HI;
                else
                    decay = data;
            end
            default: ;
        endcase
    endtask

    task automatic track_sample(input pmd_in_t item);
        logic [15:0] mag;
        logic [63:0] acc;
        pmd_out_t    reading;
        mag = item.sample[15] ? (16'(~item.sample) + 16'd1) : 16'(item.sample);
        if (mag > 16'(MAG_MAX))
            mag = 16'(MAG_MAX);
        if (PEAK_W'(mag) > block_max)
            block_max = PEAK_W'(mag);
        if (item.end_of_block) begin
            // instant attack, otherwise blend toward the block max
            if (block_max >= held_peak) begin
                held_peak = block_max;
            end else begin
                acc = 64'(held_peak) * 64'(decay)
                    + 64'(block_max) * (64'd65536 - 64'(decay));
                held_peak = PEAK_W'(acc >> 16);
            end
            block_max = '0;
            held_db   = dbfs_of(held_peak);
            reading.level   = mode_sel ? held_db : LEVEL_W'(held_peak);
            reading.peak_db = held_db;
            due_readings.push_back(reading);
        end
    endtask

    always @(posedge aclk) begin
        pmd_out_t want;
        if (!aresetn) begin
            mode_sel  = 1'b0;
            decay     = DECAY_RESET;
            block_max = '0;
            held_peak = '0;
            held_db   = DB_MIN;
            due_readings.delete();
        end else begin
            if (cfg_we)
                latch_register(cfg_index, cfg_wdata);
            if (s_valid && s_ready)
                track_sample(s_data);
            if (m_valid && m_ready) begin
                if (due_readings.size() == 0) begin
                    $error("unexpected result transaction: level %0d, peak_db %0d",
                           m_data.level, m_data.peak_db);
                    mismatch_count++;
                end else begin
                    want = due_readings.pop_front();
                    if (m_data.level !== want.level) begin
                        $error("level: expected %0d, actual %0d", want.level, m_data.level);
                        mismatch_count++;
                    end
                    if (m_data.peak_db !== want.peak_db) begin
                        $error("peak_db: expected %0d, actual %0d",
                               want.peak_db, m_data.peak_db);
                        mismatch_count++;
                    end
                end
            end
        end
        readings_due = due_readings.size();
    end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps
// Testbench top: reset, sample and register stimulus, watchdog and verdict.
module tb import pmd_pkg::*; ();

    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 245;
    localparam int SETTLE_CYCLES  = 24;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = CFG_IDX_W'(3);

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    pmd_in_t               s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    pmd_out_t              m_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    bit gaps_on = 1'b1;
    int mismatch_count;
    int readings_due;
    int idle_cycles = 0;

    // out-of-range words check bit masking and decay clamping
    logic [15:0] mode_words  [PHASES] = '{16'h0000, 16'h0001, 16'hFFFE, 16'h0001,
                                          16'h0000, 16'hFFFF, 16'h0001, 16'h0000};
    logic [15:0] decay_words [PHASES] = '{16'd0, 16'd65535, 16'd32767, 16'd65471,
                                          16'd32768, 16'd65470, 16'd0, 16'd62259};

    always #2 aclk = ~aclk;

    peak_meter_with_decay dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    pmd_checker meter_chk (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .mismatch_count (mismatch_count),
        .readings_due   (readings_due)
    );

    always @(negedge aclk) begin
        m_ready <= gaps_on ? ($urandom_range(0, 99) >= 14) : 1'b1;
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic push_sample(input logic signed [15:0] smp, input logic eob);
        if (gaps_on && $urandom_range(0, 99) < 14) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_valid             <= 1'b1;
        s_data.sample       <= smp;
        s_data.end_of_block <= eob;
        do @(posedge aclk); while (!(s_valid && s_ready));
        @(negedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    // Hold off input until every reading is back, then let the pipeline settle.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(negedge aclk); while (readings_due != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic send_block(input int profile, output int count);
        int                 len;
        int                 k;
        logic signed [15:0] smp;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
        for (k = 0; k < len; k++) begin
            case (profile)
                0, 1, 2, 3: smp = 16'($urandom);
                4, 5, 6:    smp = 16'(int'($urandom_range(0, 14)) - 7);
                7:          smp = 16'(int'($urandom_range(0, 2046)) - 1023);
                8: begin
                    case ($urandom_range(0, 5))
                        0:       smp = 16'sh7FFF;
                        1:       smp = 16'sh8000;
                        2:       smp = 16'sh8001;
                        3:       smp = 16'sh0001;
                        4:       smp = 16'shFFFF;
                        default: smp = 16'sh0000;
                    endcase
                end
                default:    smp = 16'sh0000;
            endcase
            push_sample(smp, k == len - 1);
        end
        count = len;
    endtask

    initial begin
        int          ph;
        int          sent;
        int          n;
        int          profile;
        int          run_left;
        bit          paused;
        logic [15:0] decay_word;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // linear readout, reset decay: floor edge, saturation, attack and release
        push_sample(16'sh0000, 1'b1);
        push_sample(16'sh0003, 1'b1);
        push_sample(16'sh0004, 1'b1);
        push_sample(16'shFFFC, 1'b0);
        push_sample(16'sh0002, 1'b1);
        push_sample(16'sh0001, 1'b1);
        push_sample(16'sh7FFF, 1'b0);
        push_sample(16'sh8000, 1'b1);
        push_sample(16'sh8001, 1'b1);
        push_sample(16'sh0000, 1'b0);
        push_sample(16'sh0000, 1'b0);
        push_sample(16'sh0000, 1'b1);
        push_sample(16'sh4000, 1'b1);
        push_sample(16'shFFFF, 1'b1);
        push_sample(16'shBFFF, 1'b0);
        push_sample(16'sh00FF, 1'b1);
        wait_drained();

        // dBFS readout
        write_register(CFG_OUTPUT_MODE, 16'h0001);
        push_sample(16'sh8000, 1'b1);
        push_sample(16'sh0000, 1'b1);
        push_sample(16'sh3039, 1'b0);
        push_sample(16'shFFFE, 1'b1);
        push_sample(16'sh7FFF, 1'b1);

        run_left = 0;
        profile  = 0;
        for (ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            gaps_on = (ph != 3);
            decay_word = (ph == 6) ? 16'($urandom) : decay_words[ph];
            write_register(CFG_OUTPUT_MODE, mode_words[ph]);
            write_register(CFG_DECAY_FACTOR, decay_word);
            if (ph == 5) begin
                // unmapped indexes must leave both registers alone
                write_register(CFG_SPARE_2, 16'($urandom));
                write_register(CFG_SPARE_3, 16'hFFFF);
            end
            sent   = 0;
            paused = 1'b0;
            while (sent < PHASE_ITEMS) begin
                // keep a signal profile for several blocks so quiet runs decay to the floor
                if (run_left == 0) begin
                    profile  = $urandom_range(0, 9);
                    run_left = $urandom_range(1, 16);
                end
                run_left--;
                send_block(profile, n);
                sent += n;
                if (!paused && sent >= PHASE_ITEMS / 2) begin
                    wait_drained();
                    paused = 1'b1;
                end
            end
        end
        gaps_on = 1'b1;
        wait_drained();

        if (mismatch_count == 0 && readings_due == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: peak_meter_with_decay.f
hdl/pmd_pkg.sv
hdl/pmd_front.sv
hdl/pmd_log_pipe.sv
hdl/peak_meter_with_decay.sv
hdl/pmd_checker.sv
sim/pmd_checker.sv
sim/tb.sv
